[rtl/owm_pkg.sv]
// owm_pkg: shared types, constants and timing functions for the one-wire bus master
// no dependencies; used by the interfaces and every module of the block

package owm_pkg;

  // delay counter width and the queue between front and back
  localparam int DELAY_WIDTH = 11;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic [DELAY_WIDTH-1:0] delay_t;

  // operation codes on the input word
  typedef enum logic [2:0] {
    OP_TICK      = 3'd0,
    OP_RESET     = 3'd1,
    OP_WRITE     = 3'd2,
    OP_READ      = 3'd3,
    OP_WRITEREAD = 3'd4
  } op_t;

  // command kinds held by the sequencer
  typedef enum logic [1:0] {
    KIND_RESET     = 2'd0,
    KIND_WRITE     = 2'd1,
    KIND_READ      = 2'd2,
    KIND_WRITEREAD = 2'd3
  } kind_t;

  // sequencer phases
  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_RST_PRE   = 3'd1,
    PH_RST_LOW   = 3'd2,
    PH_RST_WAIT  = 3'd3,
    PH_RST_REC   = 3'd4,
    PH_SLOT_LOW  = 3'd5,
    PH_SLOT_REL  = 3'd6,
    PH_SLOT_TAIL = 3'd7
  } phase_t;

  // slot timing segments
  typedef enum logic [3:0] {
    SEG_A = 4'd0,
    SEG_B = 4'd1,
    SEG_C = 4'd2,
    SEG_D = 4'd3,
    SEG_E = 4'd4,
    SEG_F = 4'd5,
    SEG_G = 4'd6,
    SEG_H = 4'd7,
    SEG_I = 4'd8,
    SEG_J = 4'd9
  } seg_t;

  // classified word passed from front to back
  typedef struct packed {
    logic       cmd;
    kind_t      kind;
    logic [7:0] data;
    logic       line;
  } item_t;

  // segment length in ticks, standard or overdrive
  function automatic delay_t tick_len(input logic overdrive, input seg_t seg);
    delay_t len;
    len = '0;
    if (!overdrive) begin
      case (seg)
        SEG_A:   len = DELAY_WIDTH'(24);
        SEG_B:   len = DELAY_WIDTH'(256);
        SEG_C:   len = DELAY_WIDTH'(240);
        SEG_D:   len = DELAY_WIDTH'(40);
        SEG_E:   len = DELAY_WIDTH'(36);
        SEG_F:   len = DELAY_WIDTH'(220);
        SEG_G:   len = DELAY_WIDTH'(0);
        SEG_H:   len = DELAY_WIDTH'(1920);
        SEG_I:   len = DELAY_WIDTH'(280);
        SEG_J:   len = DELAY_WIDTH'(1640);
        default: len = '0;
      endcase
    end else begin
      case (seg)
        SEG_A:   len = DELAY_WIDTH'(6);
        SEG_B:   len = DELAY_WIDTH'(30);
        SEG_C:   len = DELAY_WIDTH'(30);
        SEG_D:   len = DELAY_WIDTH'(10);
        SEG_E:   len = DELAY_WIDTH'(3);
        SEG_F:   len = DELAY_WIDTH'(28);
        SEG_G:   len = DELAY_WIDTH'(10);
        SEG_H:   len = DELAY_WIDTH'(280);
        SEG_I:   len = DELAY_WIDTH'(34);
        SEG_J:   len = DELAY_WIDTH'(160);
        default: len = '0;
      endcase
    end
    return len;
  endfunction

  // a read slot: read byte, or a one bit of write-read
  function automatic logic is_read_slot(input kind_t kind, input logic [7:0] shift);
    return (kind == KIND_READ) || ((kind == KIND_WRITEREAD) && shift[0]);
  endfunction

  // a slot that starts with the short low time
  function automatic logic is_one_bit(input kind_t kind, input logic [7:0] shift);
    return (kind == KIND_READ) || shift[0];
  endfunction

endpackage

[rtl/owm_if.sv]
// owm_in_if / owm_out_if: valid-ready channels for tick words and result words
// depends on owm_pkg

interface owm_in_if;
  import owm_pkg::*;
  logic       valid;
  logic       ready;
  logic [2:0] operation;
  logic [7:0] data_byte;
  logic       line_sample;

  modport source(output valid, output operation, output data_byte, output line_sample,
                 input ready);
  modport sink(input valid, input operation, input data_byte, input line_sample,
               output ready);
endinterface

interface owm_out_if;
  import owm_pkg::*;
  logic       valid;
  logic       ready;
  logic       drive_low;
  logic       busy_res;
  logic       done_res;
  logic [7:0] result_byte;
  logic       no_presence;
  logic       command_rejected;

  modport source(output valid, output drive_low, output busy_res, output done_res,
                 output result_byte, output no_presence, output command_rejected,
                 input ready);
  modport sink(input valid, input drive_low, input busy_res, input done_res,
               input result_byte, input no_presence, input command_rejected,
               output ready);
endinterface

[rtl/owm_front.sv]
// owm_front: accepts tick words, decodes the operation and registers the classified word
// depends on owm_pkg and owm_in_if

module owm_front (
  input  logic           clk,
  input  logic           rst,
  owm_in_if.sink         item_in,
  output owm_pkg::item_t push_item,
  output logic           push_valid,
  input  logic           push_ready
);
  import owm_pkg::*;

  logic  held;
  item_t item;
  item_t decoded;

  // decode: codes one to four are commands, anything else is a plain tick
  always_comb begin
    decoded.cmd  = (item_in.operation == OP_RESET) || (item_in.operation == OP_WRITE) ||
                   (item_in.operation == OP_READ)  || (item_in.operation == OP_WRITEREAD);
    decoded.kind = kind_t'(item_in.operation[1:0] - 2'd1);
    decoded.data = item_in.data_byte;
    decoded.line = item_in.line_sample;
  end

  // take a new word when the stage is empty or drains this cycle
  assign item_in.ready = !held || push_ready;
  assign push_valid    = held;
  assign push_item     = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (item_in.ready) begin
      held <= item_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_in.ready && item_in.valid) begin
      item <= decoded;
    end
  end

endmodule

[rtl/owm_queue.sv]
// owm_queue: short fifo of classified words between the front and the sequencer
// depends on owm_pkg

module owm_queue (
  input  logic           clk,
  input  logic           rst,
  input  owm_pkg::item_t push_item,
  input  logic           push_valid,
  output logic           push_ready,
  output owm_pkg::item_t pop_item,
  output logic           pop_valid,
  input  logic           pop_ready
);
  import owm_pkg::*;

  item_t             mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              pop;

  assign push_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = mem[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue fill count beyond depth");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + QCNT_W'(1)))
    else $error("queue count missed a push");
  a_ptr_match: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> (wr_ptr == rd_ptr))
    else $error("empty queue with pointers apart");

endmodule

[rtl/owm_seq.sv]
// owm_seq: slot sequencer that runs one tick per word and registers the result word
// depends on owm_pkg and owm_out_if

module owm_seq (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_write_en,
  input  logic           cfg_write_data,
  input  owm_pkg::item_t pop_item,
  input  logic           pop_valid,
  output logic           pop_ready,
  owm_out_if.source      result_out
);
  import owm_pkg::*;

  // sequencer state
  logic       overdrive;
  phase_t     phase;
  delay_t     delay_left;
  logic [2:0] bit_index;
  kind_t      kind;
  logic [7:0] send_shift;
  logic [7:0] receive_shift;
  logic       presence;

  phase_t     phase_next;
  delay_t     delay_left_next;
  logic [2:0] bit_index_next;
  kind_t      kind_next;
  logic [7:0] send_shift_next;
  logic [7:0] receive_shift_next;
  logic       presence_next;

  logic drive_w;
  logic done_w;
  logic reject_w;

  // output register
  logic       out_valid;
  logic       out_drive;
  logic       out_busy;
  logic       out_done;
  logic [7:0] out_byte;
  logic       out_nopres;
  logic       out_reject;

  logic step;

  assign pop_ready = !out_valid || result_out.ready;
  assign step      = pop_valid && pop_ready;

  // speed register
  always_ff @(posedge clk) begin
    if (rst) begin
      overdrive <= 1'b0;
    end else if (cfg_write_en) begin
      overdrive <= cfg_write_data;
    end
  end

  // one tick of the sequencer: start a command if idle (refuse it if busy), then count down the segment
  always_comb begin
    logic last;
    logic rd_slot;
    logic adv_bit;
    phase_next         = phase;
    delay_left_next    = delay_left;
    bit_index_next     = bit_index;
    kind_next          = kind;
    send_shift_next    = send_shift;
    receive_shift_next = receive_shift;
    presence_next      = presence;
    drive_w            = 1'b0;
    done_w             = 1'b0;
    reject_w           = 1'b0;
    last               = 1'b0;
    rd_slot            = 1'b0;
    adv_bit            = 1'b0;

    // command start; the first segment runs on this same tick
    if (phase == PH_IDLE) begin
      if (pop_item.cmd) begin
        kind_next       = pop_item.kind;
        send_shift_next = pop_item.data;
        bit_index_next  = '0;
        if (pop_item.kind == KIND_RESET) begin
          if (tick_len(overdrive, SEG_G) != '0) begin
            phase_next      = PH_RST_PRE;
            delay_left_next = tick_len(overdrive, SEG_G);
          end else begin
            phase_next      = PH_RST_LOW;
            delay_left_next = tick_len(overdrive, SEG_H);
          end
        end else begin
          phase_next      = PH_SLOT_LOW;
          delay_left_next = is_one_bit(pop_item.kind, pop_item.data) ?
                            tick_len(overdrive, SEG_A) : tick_len(overdrive, SEG_C);
        end
      end
    end else if (pop_item.cmd) begin
      reject_w = 1'b1;
    end

    if (phase_next != PH_IDLE) begin
      last    = (delay_left_next <= DELAY_WIDTH'(1));
      rd_slot = is_read_slot(kind_next, send_shift_next);
      drive_w = (phase_next == PH_RST_LOW) || (phase_next == PH_SLOT_LOW);

      // presence sample at the end of the wait
      if (last && phase_next == PH_RST_WAIT) begin
        presence_next = pop_item.line;
      end
      // data sample at the end of the release part
      if (last && phase_next == PH_SLOT_REL &&
          (kind_next == KIND_READ || kind_next == KIND_WRITEREAD)) begin
        receive_shift_next = {rd_slot && pop_item.line, receive_shift_next[7:1]};
      end

      if (!last) begin
        delay_left_next = delay_left_next - DELAY_WIDTH'(1);
      end else begin
        case (phase_next)
          PH_RST_PRE: begin
            phase_next      = PH_RST_LOW;
            delay_left_next = tick_len(overdrive, SEG_H);
          end
          PH_RST_LOW: begin
            phase_next      = PH_RST_WAIT;
            delay_left_next = tick_len(overdrive, SEG_I) + DELAY_WIDTH'(1);
          end
          PH_RST_WAIT: begin
            phase_next      = PH_RST_REC;
            delay_left_next = tick_len(overdrive, SEG_J) - DELAY_WIDTH'(1);
          end
          PH_RST_REC: begin
            phase_next      = PH_IDLE;
            delay_left_next = '0;
            done_w          = 1'b1;
          end
          PH_SLOT_LOW: begin
            phase_next = PH_SLOT_REL;
            if (rd_slot) begin
              delay_left_next = tick_len(overdrive, SEG_E) + DELAY_WIDTH'(1);
            end else if (is_one_bit(kind_next, send_shift_next)) begin
              delay_left_next = tick_len(overdrive, SEG_B);
            end else begin
              delay_left_next = tick_len(overdrive, SEG_D);
            end
          end
          PH_SLOT_REL: begin
            if (rd_slot) begin
              phase_next      = PH_SLOT_TAIL;
              delay_left_next = tick_len(overdrive, SEG_F) - DELAY_WIDTH'(1);
            end else begin
              adv_bit = 1'b1;
            end
          end
          default: begin
            adv_bit = 1'b1;
          end
        endcase
      end

      // move on to the next bit or finish the byte
      if (adv_bit) begin
        send_shift_next = {1'b0, send_shift_next[7:1]};
        if (bit_index_next == 3'd7) begin
          phase_next      = PH_IDLE;
          delay_left_next = '0;
          done_w          = 1'b1;
        end else begin
          bit_index_next  = bit_index_next + 3'd1;
          phase_next      = PH_SLOT_LOW;
          delay_left_next = is_one_bit(kind_next, send_shift_next) ?
                            tick_len(overdrive, SEG_A) : tick_len(overdrive, SEG_C);
        end
      end
    end
  end

  // state update, one tick per word taken
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      delay_left    <= '0;
      bit_index     <= '0;
      kind          <= KIND_RESET;
      send_shift    <= '0;
      receive_shift <= '0;
      presence      <= 1'b0;
    end else if (step) begin
      phase         <= phase_next;
      delay_left    <= delay_left_next;
      bit_index     <= bit_index_next;
      kind          <= kind_next;
      send_shift    <= send_shift_next;
      receive_shift <= receive_shift_next;
      presence      <= presence_next;
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop_ready) begin
      out_valid <= pop_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_drive  <= drive_w;
      out_busy   <= (phase_next != PH_IDLE);
      out_done   <= done_w;
      out_byte   <= receive_shift_next;
      out_nopres <= presence_next;
      out_reject <= reject_w;
    end
  end

  assign result_out.valid            = out_valid;
  assign result_out.drive_low        = out_drive;
  assign result_out.busy_res         = out_busy;
  assign result_out.done_res         = out_done;
  assign result_out.result_byte      = out_byte;
  assign result_out.no_presence      = out_nopres;
  assign result_out.command_rejected = out_reject;

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_done) |-> !out_busy)
    else $error("done word still reports busy");
  a_idle_delay: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_IDLE) |-> (delay_left == '0))
    else $error("idle sequencer with a pending delay");
  a_reset_kind: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_RST_PRE || phase == PH_RST_LOW || phase == PH_RST_WAIT ||
     phase == PH_RST_REC) |-> (kind == KIND_RESET))
    else $error("reset phase under a byte command");
  a_hold_state: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(phase) && $stable(delay_left))
    else $error("sequencer moved without a tick");

endmodule

[rtl/one_wire_bus_master_unit.sv]
// one_wire_bus_master_unit: top level of the one-wire bus master
// depends on owm_pkg, owm_if, owm_front, owm_queue and owm_seq
// a tick word passes the front register, the two-word queue and the result word register in turn
// throughput: one tick word per cycle while the result side is ready, as the sequencer steps once per word taken
// the front register and the two-word queue absorb stalls on the result side
// reset (rst, synchronous): sequencer idle with cleared state, standard speed, queues empty

module one_wire_bus_master_unit (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_write_en,
  input  logic      cfg_write_data,
  owm_in_if.sink    item_in,
  owm_out_if.source result_out
);
  import owm_pkg::*;

  item_t push_item;
  logic  push_valid;
  logic  push_ready;
  item_t pop_item;
  logic  pop_valid;
  logic  pop_ready;

  // classify incoming words
  owm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_in    (item_in),
    .push_item  (push_item),
    .push_valid (push_valid),
    .push_ready (push_ready)
  );

  // decoupling queue
  owm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_item  (push_item),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .pop_item   (pop_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready)
  );

  // slot sequencer and result register
  owm_seq u_seq (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .pop_item       (pop_item),
    .pop_valid      (pop_valid),
    .pop_ready      (pop_ready),
    .result_out     (result_out)
  );

endmodule

[sim/tb_top.sv]
// tb_top: self-checking bench for one_wire_bus_master_unit, tick words in and result words out
// depends on owm_pkg, owm_if and the rtl top; an internal slot-timing model predicts each result

module tb_top;
  import owm_pkg::*;

  localparam logic       SPEED_STD       = 1'b0;
  localparam logic       SPEED_OVD       = 1'b1;
  // codes above OP_WRITEREAD carry no command and act as a plain tick
  localparam logic [2:0] OP_LAST_CODE    = 3'd7;
  localparam int         RANDOM_COMMANDS = 60;
  localparam int         MAX_REPORTS     = 40;
  localparam int         SETTLE_CYCLES   = 20;

  // sequencer state as the bench tracks it
  typedef struct packed {
    phase_t     phase;
    delay_t     delay_left;
    logic [2:0] bit_index;
    kind_t      kind;
    logic [7:0] send_shift;
    logic [7:0] recv_shift;
    logic       presence;
  } bus_state_t;

  // one result word
  typedef struct packed {
    logic       drive_low;
    logic       busy;
    logic       done;
    logic [7:0] result_byte;
    logic       no_presence;
    logic       rejected;
  } bus_word_t;

  logic clk;
  logic rst;
  logic cfg_write_en;
  logic cfg_write_data;

  owm_in_if  item_ch();
  owm_out_if result_ch();

  one_wire_bus_master_unit dut (
    .clk(clk),
    .rst(rst),
    .cfg_write_en(cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .item_in(item_ch),
    .result_out(result_ch)
  );

  // segment lengths A..J in ticks, standard row then overdrive row
  int unsigned slot_ticks [2][10] = '{
    '{24, 256, 240, 40, 36, 220, 0, 1920, 280, 1640},
    '{6, 30, 30, 10, 3, 28, 10, 280, 34, 160}
  };

  bus_state_t  master_state;
  logic        master_speed;
  bus_word_t   pending_words[$];
  bit          steady = 1'b0;
  int          fail_count = 0;
  int          words_sent = 0;
  int          commands_done = 0;
  int          commands_refused = 0;
  int          speed_writes = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit
  initial begin
    #32_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

  // ---------------------------------------------------------------- slot model

  function automatic int unsigned seg_ticks(input logic spd, input seg_t seg);
    return slot_ticks[spd][seg];
  endfunction

  // slot that samples the line: every read bit, and one bits of write-read
  function automatic logic reads_slot(input bus_state_t st);
    return (st.kind == KIND_READ) || ((st.kind == KIND_WRITEREAD) && st.send_shift[0]);
  endfunction

  // slot that opens with the short low time
  function automatic logic short_low(input bus_state_t st);
    return (st.kind == KIND_READ) || st.send_shift[0];
  endfunction

  function automatic void enter(inout bus_state_t st, input phase_t ph, input int unsigned len);
    st.phase      = ph;
    st.delay_left = delay_t'(len);
  endfunction

  function automatic void begin_slot(inout bus_state_t st, input logic spd);
    enter(st, PH_SLOT_LOW, short_low(st) ? seg_ticks(spd, SEG_A) : seg_ticks(spd, SEG_C));
  endfunction

  // move to the next bit; 1 when the byte is finished
  function automatic logic next_bit(inout bus_state_t st, input logic spd);
    st.send_shift = st.send_shift >> 1;
    if (st.bit_index == 3'd7) begin
      enter(st, PH_IDLE, 0);
      return 1'b1;
    end
    st.bit_index = st.bit_index + 3'd1;
    begin_slot(st, spd);
    return 1'b0;
  endfunction

  // one tick of the master: state update and the result word it gives
  function automatic void master_tick(inout bus_state_t st, input logic spd,
                                      input logic [2:0] op, input logic [7:0] data,
                                      input logic line, output bus_word_t r);
    logic cmd;
    logic last;
    logic finished;
    r        = '0;
    finished = 1'b0;
    cmd      = (op >= 3'(OP_RESET)) && (op <= 3'(OP_WRITEREAD));

    // command start, or refusal while busy
    if (st.phase == PH_IDLE) begin
      if (cmd) begin
        st.kind       = kind_t'(op - 3'(OP_RESET));
        st.send_shift = data;
        st.bit_index  = 3'd0;
        if (st.kind == KIND_RESET) begin
          // standard speed has no pre-reset wait
          if (seg_ticks(spd, SEG_G) != 0) enter(st, PH_RST_PRE, seg_ticks(spd, SEG_G));
          else enter(st, PH_RST_LOW, seg_ticks(spd, SEG_H));
        end else begin
          begin_slot(st, spd);
        end
      end
    end else if (cmd) begin
      r.rejected = 1'b1;
    end

    // segment countdown and transitions
    if (st.phase != PH_IDLE) begin
      last        = st.delay_left <= delay_t'(1);
      r.drive_low = (st.phase == PH_RST_LOW) || (st.phase == PH_SLOT_LOW);
      if (last && st.phase == PH_RST_WAIT) st.presence = line;
      if (last && st.phase == PH_SLOT_REL &&
          (st.kind == KIND_READ || st.kind == KIND_WRITEREAD)) begin
        st.recv_shift = {reads_slot(st) && line, st.recv_shift[7:1]};
      end
      if (!last) begin
        st.delay_left = st.delay_left - 1'b1;
      end else begin
        case (st.phase)
          PH_RST_PRE:  enter(st, PH_RST_LOW, seg_ticks(spd, SEG_H));
          PH_RST_LOW:  enter(st, PH_RST_WAIT, seg_ticks(spd, SEG_I) + 1);
          PH_RST_WAIT: enter(st, PH_RST_REC, seg_ticks(spd, SEG_J) - 1);
          PH_RST_REC: begin
            enter(st, PH_IDLE, 0);
            finished = 1'b1;
          end
          PH_SLOT_LOW: begin
            if (reads_slot(st)) enter(st, PH_SLOT_REL, seg_ticks(spd, SEG_E) + 1);
            else if (short_low(st)) enter(st, PH_SLOT_REL, seg_ticks(spd, SEG_B));
            else enter(st, PH_SLOT_REL, seg_ticks(spd, SEG_D));
          end
          PH_SLOT_REL: begin
            if (reads_slot(st)) enter(st, PH_SLOT_TAIL, seg_ticks(spd, SEG_F) - 1);
            else finished = next_bit(st, spd);
          end
          default: finished = next_bit(st, spd);
        endcase
      end
    end

    r.busy        = st.phase != PH_IDLE;
    r.done        = finished;
    r.result_byte = st.recv_shift;
    r.no_presence = st.presence;
  endfunction

  // ---------------------------------------------------------------- drivers

  function automatic logic pick_line(input int unsigned pct);
    return $urandom_range(99) < pct;
  endfunction

  // send one tick word and predict its result once taken
  task automatic send_word(input logic [2:0] op, input logic [7:0] data, input logic line);
    bus_word_t w;
    while (!steady && $urandom_range(99) < 10) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid       <= 1'b1;
    item_ch.operation   <= op;
    item_ch.data_byte   <= data;
    item_ch.line_sample <= line;
    do @(negedge clk); while (item_ch.ready !== 1'b1);
    @(posedge clk);
    master_tick(master_state, master_speed, op, data, line, w);
    pending_words.push_back(w);
    words_sent++;
    if (w.done) commands_done++;
    if (w.rejected) commands_refused++;
  endtask

  // tick until the running command ends; done_op goes out on its last tick
  task automatic finish_command(input int unsigned line_pct, input int unsigned noise_pct,
                                input logic [2:0] done_op);
    bus_state_t probe;
    bus_word_t  peek;
    logic [2:0] op;
    while (master_state.phase != PH_IDLE) begin
      op = OP_TICK;
      if ($urandom_range(99) < noise_pct) op = 3'($urandom_range(OP_RESET, OP_LAST_CODE));
      probe = master_state;
      master_tick(probe, master_speed, OP_TICK, 8'h00, 1'b0, peek);
      if (peek.done) op = done_op;
      send_word(op, 8'($urandom_range(255)), pick_line(line_pct));
    end
  endtask

  task automatic run_command(input logic [2:0] op, input logic [7:0] data,
                             input int unsigned line_pct, input int unsigned noise_pct,
                             input logic [2:0] done_op);
    send_word(op, data, pick_line(line_pct));
    finish_command(line_pct, noise_pct, done_op);
  endtask

  // stop sending and wait for every predicted word
  task automatic wait_drained;
    item_ch.valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
  endtask

  // one register write, then cfg_write_en low again before returning, so back-to-back writes stay apart
  task automatic set_speed(input logic spd);
    wait_drained();
    cfg_write_en   <= 1'b1;
    cfg_write_data <= spd;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    master_speed = spd;
    speed_writes++;
    @(posedge clk);
  endtask

  // result side back-pressure
  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      result_ch.ready <= !rst && (steady || $urandom_range(99) >= 10);
    end
  end

  // ---------------------------------------------------------------- checking

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      if (fail_count < MAX_REPORTS) $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  // compare each taken result word against the oldest prediction
  always @(negedge clk) begin
    bus_word_t want;
    if (!rst && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
      if (pending_words.size() == 0) begin
        if (fail_count < MAX_REPORTS) $error("result word arrived with nothing expected");
        fail_count++;
      end else begin
        want = pending_words.pop_front();
        check_field("drive_low", 8'(want.drive_low), 8'(result_ch.drive_low));
        check_field("busy_res", 8'(want.busy), 8'(result_ch.busy_res));
        check_field("done_res", 8'(want.done), 8'(result_ch.done_res));
        check_field("result_byte", want.result_byte, result_ch.result_byte);
        check_field("no_presence", 8'(want.no_presence), 8'(result_ch.no_presence));
        check_field("command_rejected", 8'(want.rejected), 8'(result_ch.command_rejected));
      end
    end
  end

  // ---------------------------------------------------------------- tests

  // standard timing, including the reset without a pre-reset wait
  task automatic test_standard_speed;
    set_speed(SPEED_STD);
    run_command(OP_RESET, 8'h00, 100, 0, OP_TICK);
    run_command(OP_RESET, 8'hFF, 0, 0, OP_TICK);
    run_command(OP_WRITE, 8'hA5, 50, 0, OP_TICK);
    run_command(OP_READ, 8'h00, 50, 0, OP_TICK);
    run_command(OP_WRITEREAD, 8'h3C, 50, 0, OP_TICK);
  endtask

  // overdrive timing, byte and line extremes
  task automatic test_overdrive_speed;
    set_speed(SPEED_OVD);
    run_command(OP_RESET, 8'h00, 100, 0, OP_TICK);
    run_command(OP_RESET, 8'hFF, 0, 0, OP_TICK);
    run_command(OP_WRITE, 8'h00, 0, 0, OP_TICK);
    run_command(OP_WRITE, 8'hFF, 100, 0, OP_TICK);
    run_command(OP_READ, 8'h00, 0, 0, OP_TICK);
    run_command(OP_READ, 8'hFF, 100, 0, OP_TICK);
    run_command(OP_WRITEREAD, 8'hFF, 100, 0, OP_TICK);
    run_command(OP_WRITEREAD, 8'h00, 100, 0, OP_TICK);
    run_command(OP_WRITEREAD, 8'h96, 50, 0, OP_TICK);
  endtask

  // plain ticks and unassigned codes while idle
  task automatic test_idle_words;
    send_word(OP_TICK, 8'hFF, 1'b1);
    for (int op = OP_WRITEREAD + 1; op <= OP_LAST_CODE; op++) begin
      send_word(3'(op), 8'($urandom_range(255)), 1'($urandom_range(1)));
    end
  endtask

  // every code arriving while a command runs
  task automatic test_busy_commands;
    send_word(OP_READ, 8'h00, 1'b1);
    for (int op = OP_RESET; op <= OP_LAST_CODE; op++) begin
      send_word(3'(op), 8'($urandom_range(255)), 1'b0);
    end
    finish_command(50, 0, OP_TICK);
  endtask

  // a command on the done tick is refused; the next tick may start one
  task automatic test_done_tick_commands;
    run_command(OP_WRITE, 8'h0F, 50, 0, OP_RESET);
    run_command(OP_RESET, 8'h00, 0, 0, OP_WRITEREAD);
    run_command(OP_READ, 8'hFF, 50, 0, OP_READ);
  endtask

  // speed register rewritten while a command is part way through
  task automatic test_speed_change_midway;
    send_word(OP_WRITE, 8'h69, 1'b1);
    repeat (50) send_word(OP_TICK, 8'($urandom_range(255)), pick_line(50));
    set_speed(SPEED_STD);
    finish_command(50, 0, OP_TICK);
    send_word(OP_RESET, 8'h00, 1'b0);
    repeat (100) send_word(OP_TICK, 8'($urandom_range(255)), 1'b0);
    set_speed(SPEED_OVD);
    finish_command(0, 0, OP_TICK);
    set_speed(SPEED_STD);
    send_word(OP_READ, 8'h00, 1'b1);
    repeat (30) send_word(OP_TICK, 8'($urandom_range(255)), pick_line(50));
    set_speed(SPEED_OVD);
    finish_command(50, 0, OP_TICK);
  endtask

  // random commands, mostly overdrive, with noise between and inside them
  task automatic test_random_traffic;
    logic [2:0]  op;
    logic [2:0]  done_op;
    logic [7:0]  data;
    int unsigned mode;
    int unsigned line_pct;
    int unsigned noise_pct;
    for (int n = 0; n < RANDOM_COMMANDS; n++) begin
      steady = (n >= 20) && (n < 35);
      repeat ($urandom_range(3)) begin
        send_word($urandom_range(1) ? 3'(OP_TICK)
                                    : 3'($urandom_range(OP_WRITEREAD + 1, OP_LAST_CODE)),
                  8'($urandom_range(255)), 1'($urandom_range(1)));
      end
      mode      = $urandom_range(99);
      op        = 3'($urandom_range(OP_RESET, OP_WRITEREAD));
      data      = 8'($urandom_range(255));
      case ($urandom_range(3))
        0:       line_pct = 0;
        1:       line_pct = 100;
        default: line_pct = 50;
      endcase
      noise_pct = ($urandom_range(9) == 0) ? 5 : 0;
      done_op   = ($urandom_range(9) == 0) ? 3'($urandom_range(OP_RESET, OP_WRITEREAD))
                                           : 3'(OP_TICK);
      if (mode < 2) set_speed(SPEED_STD);
      if (mode == 2) begin
        // drop to standard timing part way through
        send_word(op, data, pick_line(line_pct));
        repeat ($urandom_range(1, 120)) begin
          send_word(OP_TICK, 8'($urandom_range(255)), pick_line(line_pct));
        end
        set_speed(SPEED_STD);
        finish_command(line_pct, noise_pct, done_op);
      end else begin
        run_command(op, data, line_pct, noise_pct, done_op);
      end
      if (master_speed != SPEED_OVD) set_speed(SPEED_OVD);
    end
    steady = 1'b0;
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    rst                 = 1'b1;
    cfg_write_en        = 1'b0;
    cfg_write_data      = 1'b0;
    item_ch.valid       = 1'b0;
    item_ch.operation   = OP_TICK;
    item_ch.data_byte   = 8'h00;
    item_ch.line_sample = 1'b1;
    master_state        = '0;
    master_speed        = SPEED_STD;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_standard_speed();
    test_overdrive_speed();
    test_idle_words();
    test_busy_commands();
    test_done_tick_commands();
    test_speed_change_midway();
    test_random_traffic();

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("tb_top: %0d tick words, %0d commands completed, %0d refused while busy",
             words_sent, commands_done, commands_refused);
    $display("tb_top: %0d speed register writes across standard and overdrive timing",
             speed_writes);
    if (fail_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
